// ===== hw/rtl/bls_pkg.sv =====
// Shared constants, codes and types for the bounded LIFO stack.
package bls_pkg;

    localparam int MAX_DEPTH = 16;
    localparam int DATA_W    = 32;
    localparam int CAP_W     = 5;
    localparam int CNT_W     = $clog2(MAX_DEPTH + 1);
    localparam int IDX_W     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int CMP_W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    typedef enum logic [1:0] {
        OP_PUSH    = 2'd0,
        OP_PEEK    = 2'd1,
        OP_POP     = 2'd2,
        OP_DISPLAY = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Chain movement: hold, shift toward the bottom, shift toward the top
    typedef enum logic [1:0] {
        CH_HOLD,
        CH_DOWN,
        CH_UP
    } chain_op_t;

    typedef struct packed {
        chain_op_t               op;
        logic [DATA_W-1:0]       head_data;
        logic [IDX_W-1:0]        bottom_idx;
    } chain_ctrl_t;

endpackage

// ===== hw/rtl/bls_cell.sv =====
// One storage cell of the stack chain; moves its word to a neighbor on command.
module bls_cell import bls_pkg::*; (
    input  logic              aclk,
    input  chain_ctrl_t       ctrl,
    input  logic [IDX_W-1:0]  cell_idx,
    input  logic [DATA_W-1:0] up_data,
    input  logic [DATA_W-1:0] down_data,
    output logic [DATA_W-1:0] data_out,
    output logic [DATA_W-1:0] tap_out
);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    // Take the word from the neighbor above or below, or hold
    always_comb begin
        unique case (ctrl.op)
            CH_DOWN: data_next = up_data;
            CH_UP:   data_next = down_data;
            default: data_next = data_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_out = data_reg;

    // Drive the bottom tap only when this cell holds the oldest word
    assign tap_out = (ctrl.bottom_idx == cell_idx) ? data_reg : '0;

endmodule

// ===== hw/rtl/bls_ctrl.sv =====
// Sequencer: capacity register, entry count, display walk and result register.
module bls_ctrl import bls_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [CAP_W-1:0]  cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_opcode,
    input  logic [DATA_W-1:0] s_push_value,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [DATA_W-1:0] m_read_value,
    output logic [1:0]        m_status,
    output logic              m_last,
    input  logic [DATA_W-1:0] top_data,
    input  logic [DATA_W-1:0] bottom_data,
    output chain_ctrl_t       chain_ctrl
);

    typedef enum logic {
        CS_IDLE,
        CS_DISP
    } ctrl_state_t;

    ctrl_state_t       state_reg, state_next;
    logic [CAP_W-1:0]  cap_reg, cap_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  step_reg, step_next;
    logic              m_valid_reg, m_valid_next;
    logic [DATA_W-1:0] value_reg, value_next;
    status_t           status_reg, status_next;
    logic              last_reg, last_next;

    logic [CMP_W-1:0]  cap_ext;
    logic [CMP_W-1:0]  depth_ext;
    logic [CNT_W-1:0]  cap_use;
    logic [CNT_W-1:0]  cnt_dec;
    logic              out_free;
    logic              accept;
    logic              count_zero;
    logic              stack_full;
    logic              walk_last;

    // Capacity in use saturates at the chain length
    assign cap_ext   = CMP_W'(cap_reg);
    assign depth_ext = CMP_W'(MAX_DEPTH);
    assign cap_use   = (cap_ext > depth_ext) ? CNT_W'(depth_ext) : CNT_W'(cap_ext);

    assign cnt_dec    = count_reg - CNT_W'(1);
    assign count_zero = (count_reg == '0);
    assign stack_full = (count_reg >= cap_use);
    assign walk_last  = (step_reg == cnt_dec[IDX_W-1:0]);

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == CS_IDLE) && out_free;
    assign accept   = s_valid && s_ready;

    always_comb begin
        state_next   = state_reg;
        cap_next     = cap_reg;
        count_next   = count_reg;
        step_next    = step_reg;
        m_valid_next = m_valid_reg && !m_ready;
        value_next   = value_reg;
        status_next  = status_reg;
        last_next    = last_reg;

        chain_ctrl.op         = CH_HOLD;
        chain_ctrl.head_data  = s_push_value;
        chain_ctrl.bottom_idx = cnt_dec[IDX_W-1:0];

        unique case (state_reg)
            CS_IDLE: begin
                if (accept) begin
                    m_valid_next = 1'b1;
                    value_next   = '0;
                    last_next    = 1'b1;
                    status_next  = ST_EMPTY;
                    unique case (opcode_t'(s_opcode))
                        OP_PUSH: begin
                            if (stack_full) begin
                                status_next = ST_FULL;
                            end else begin
                                chain_ctrl.op = CH_DOWN;
                                count_next    = count_reg + CNT_W'(1);
                                status_next   = ST_OK;
                            end
                        end
                        OP_PEEK: begin
                            if (!count_zero) begin
                                value_next  = top_data;
                                status_next = ST_OK;
                            end
                        end
                        OP_POP: begin
                            if (!count_zero) begin
                                chain_ctrl.op = CH_UP;
                                count_next    = cnt_dec;
                                value_next    = top_data;
                                status_next   = ST_OK;
                            end
                        end
                        OP_DISPLAY: begin
                            if (!count_zero) begin
                                // Results come from the walk, one per cycle while the output is not stalled
                                m_valid_next = 1'b0;
                                state_next   = CS_DISP;
                                step_next    = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            CS_DISP: begin
                // Emit the bottom word and rotate it to the head of the chain
                if (out_free) begin
                    chain_ctrl.op        = CH_DOWN;
                    chain_ctrl.head_data = bottom_data;
                    m_valid_next         = 1'b1;
                    value_next           = bottom_data;
                    status_next          = ST_OK;
                    last_next            = walk_last;
                    step_next            = step_reg + IDX_W'(1);
                    if (walk_last) begin
                        state_next = CS_IDLE;
                    end
                end
            end
            default: begin
                state_next = CS_IDLE;
            end
        endcase

        // A capacity write empties the stack
        if (cfg_wr_en) begin
            cap_next   = cfg_wr_data;
            count_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= CS_IDLE;
            cap_reg     <= '0;
            count_reg   <= '0;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cap_reg     <= cap_next;
            count_reg   <= count_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
        value_reg  <= value_next;
        status_reg <= status_next;
        last_reg   <= last_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_read_value = value_reg;
    assign m_status     = status_reg;
    assign m_last       = last_reg;

`ifndef SYNTH
    a_count_in_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= cap_use)
        else $error("entry count above capacity in use");

    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (opcode_t'(s_opcode) == OP_PUSH) && !stack_full && !cfg_wr_en)
        |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("accepted push did not grow the stack");

    a_pop_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (opcode_t'(s_opcode) == OP_POP) && !count_zero && !cfg_wr_en)
        |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("accepted pop did not shrink the stack");

    a_walk_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == CS_DISP) |-> (!count_zero && !s_ready))
        else $error("display walk on empty stack or input open");

    a_walk_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == CS_DISP && out_free && walk_last && !cfg_wr_en)
        |=> (state_reg == CS_IDLE && m_valid && m_last))
        else $error("display walk did not close with a last item");
`endif

endmodule

// ===== hw/rtl/bounded_lifo_stack_core.sv =====
// Top level of the bounded LIFO stack: sequencer and chain of storage cells.
//
//   channel   direction  handshake          payload
//   s_        in         s_valid / s_ready  s_opcode, s_push_value
//   m_        out        m_valid / m_ready  m_read_value, m_status, m_last
//   cfg_      in         cfg_wr_en          cfg_wr_data (capacity, write empties stack)
//
// Push, peek and pop each give one result; the top word sits in the first cell.
// Display gives one item per stored word (a single empty-status result when
// empty): the chain rotates one cell per cycle while m_ready does not stall
// it, and each item comes from the bottom cell.
// Reset (aresetn low, synchronous) sets capacity 0 and an empty stack.
// A stalled m_ready holds the result register and closes s_ready.
module bounded_lifo_stack_core import bls_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [CAP_W-1:0]         cfg_wr_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [1:0]               s_opcode,
    input  logic signed [DATA_W-1:0] s_push_value,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_read_value,
    output logic [1:0]               m_status,
    output logic                     m_last
);

    chain_ctrl_t       chain_ctrl;
    logic [DATA_W-1:0] cell_data [MAX_DEPTH];
    logic [DATA_W-1:0] cell_tap  [MAX_DEPTH];
    logic [DATA_W-1:0] bottom_data;
    logic [DATA_W-1:0] read_value;

    bls_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_opcode     (s_opcode),
        .s_push_value (s_push_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_value (read_value),
        .m_status     (m_status),
        .m_last       (m_last),
        .top_data     (cell_data[0]),
        .bottom_data  (bottom_data),
        .chain_ctrl   (chain_ctrl)
    );

    assign m_read_value = read_value;

    // Chain of cells: cell 0 is the top, the head takes new or rotated words
    for (genvar i = 0; i < MAX_DEPTH; i++) begin : g_cell
        logic [DATA_W-1:0] up_data;
        logic [DATA_W-1:0] down_data;

        if (i == 0) begin : g_head
            assign up_data = chain_ctrl.head_data;
        end else begin : g_body
            assign up_data = cell_data[i-1];
        end

        if (i == MAX_DEPTH - 1) begin : g_tail
            assign down_data = '0;
        end else begin : g_inner
            assign down_data = cell_data[i+1];
        end

        bls_cell u_cell (
            .aclk      (aclk),
            .ctrl      (chain_ctrl),
            .cell_idx  (IDX_W'(i)),
            .up_data   (up_data),
            .down_data (down_data),
            .data_out  (cell_data[i]),
            .tap_out   (cell_tap[i])
        );
    end

    // Combine the bottom taps; only the bottom cell drives a nonzero word
    always_comb begin
        bottom_data = '0;
        for (int k = 0; k < MAX_DEPTH; k++) begin
            bottom_data = bottom_data | cell_tap[k];
        end
    end

endmodule
